### sv/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/sqw_pkg.sv
// types, tables and state update functions of the square wave channel
package sqw_pkg;

  typedef enum logic [2:0] {
    CMD_REG_WRITE     = 3'd0,
    CMD_ENABLE_WRITE  = 3'd1,
    CMD_TIMER_TICK    = 3'd2,
    CMD_QUARTER_FRAME = 3'd3,
    CMD_HALF_FRAME    = 3'd4
  } command_t;

  typedef enum logic [1:0] {
    REG_VOLUME      = 2'd0,
    REG_SWEEP       = 2'd1,
    REG_PERIOD_LOW  = 2'd2,
    REG_PERIOD_HIGH = 2'd3
  } reg_select_t;

  localparam logic [11:0] TARGET_MAX = 12'h7FF;
  localparam logic [10:0] PERIOD_MIN = 11'd8;
  localparam logic [3:0]  DECAY_TOP  = 4'd15;

  // bit {duty_mode, position} gives the wave bit
  localparam logic [31:0] DUTY_TABLE = 32'hF91E0602;

  localparam logic [7:0] LEN_TABLE [32] = '{
    8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
    8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
    8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
    8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
  };

  typedef struct packed {
    logic [1:0]  duty_mode;
    logic [2:0]  sequence_position;
    logic        wave_bit;
    logic [10:0] period_timer;
    logic [10:0] period_value;
    logic [3:0]  envelope_period;
    logic        constant_volume;
    logic        halt_loop;
    logic        halt_pending;
    logic        halt_value;
    logic        envelope_start;
    logic [3:0]  envelope_divider;
    logic [3:0]  decay_level;
    logic [7:0]  length_count;
    logic        channel_enabled;
    logic [7:0]  sweep_fields;
    logic [2:0]  sweep_divider;
    logic        sweep_reload;
  } chan_state_t;

  function automatic logic [11:0] sweep_target(input logic [10:0] period,
                                               input logic [7:0] fields,
                                               input logic ones);
    logic [11:0] change;
    logic [11:0] sub;
    logic [11:0] p;
    p = {1'b0, period};
    change = {1'b0, period >> fields[2:0]};
    sub = change + {11'd0, ones};
    if (fields[3]) begin
      sweep_target = (sub > p) ? 12'd0 : p - sub;
    end else begin
      sweep_target = p + change;
    end
  endfunction

  function automatic logic sweep_mute(input logic [10:0] period,
                                      input logic [7:0] fields,
                                      input logic ones);
    sweep_mute = (sweep_target(period, fields, ones) > TARGET_MAX) ||
                 (period < PERIOD_MIN);
  endfunction

  function automatic chan_state_t clock_envelope(input chan_state_t s);
    chan_state_t r;
    r = s;
    if (s.envelope_start) begin
      r.envelope_start = 1'b0;
      r.decay_level = DECAY_TOP;
      r.envelope_divider = s.envelope_period;
    end else if (s.envelope_divider == 4'd0) begin
      r.envelope_divider = s.envelope_period;
      if (s.decay_level == 4'd0) begin
        if (s.halt_loop) begin
          r.decay_level = DECAY_TOP;
        end
      end else begin
        r.decay_level = s.decay_level - 4'd1;
      end
    end else begin
      r.envelope_divider = s.envelope_divider - 4'd1;
    end
    return r;
  endfunction

  function automatic chan_state_t clock_length(input chan_state_t s);
    chan_state_t r;
    r = s;
    if (!s.halt_loop && s.length_count != 8'd0) begin
      r.length_count = s.length_count - 8'd1;
    end
    return r;
  endfunction

  function automatic chan_state_t clock_sweep(input chan_state_t s, input logic ones);
    chan_state_t r;
    logic [11:0] tgt;
    r = s;
    tgt = sweep_target(s.period_value, s.sweep_fields, ones);
    if (s.sweep_divider == 3'd0 && s.sweep_fields[7] &&
        !sweep_mute(s.period_value, s.sweep_fields, ones) &&
        s.sweep_fields[2:0] != 3'd0) begin
      r.period_value = tgt[10:0];
    end
    if (s.sweep_divider == 3'd0 || s.sweep_reload) begin
      r.sweep_divider = s.sweep_fields[6:4];
      r.sweep_reload = 1'b0;
    end else begin
      r.sweep_divider = s.sweep_divider - 3'd1;
    end
    return r;
  endfunction

endpackage

### sv/square_wave_channel_with_sweep.sv
// square wave channel with duty sequencer, envelope, length counter and sweep
// One request is taken every clock while item_stall is low. A request goes
// into the input register; when it leaves, the channel state is updated from it
// and the sample and length status are written into the result register.
// The sustained rate is one request per clock while the result side does not
// stall. A full result register that is stalled holds the input register,
// and then item_stall rises.
// ones_complement_negate resets to 1 and is written through cfg_data.
module square_wave_channel_with_sweep (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [2:0] command,
  input  logic [1:0] reg_select,
  input  logic [7:0] data,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [3:0] sample,
  output logic       length_active,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);
  import sqw_pkg::*;

  `include "assert_macros.svh"

  logic        ones_complement_negate;
  logic        stg_valid;
  logic [2:0]  stg_command;
  logic [1:0]  stg_reg_select;
  logic [7:0]  stg_data;
  logic        adv;
  logic        fire;
  chan_state_t st;
  chan_state_t st_next;
  logic [3:0]  vol;
  logic [3:0]  sample_next;

  assign cfg_ready  = 1'b1;
  assign adv        = !result_valid || !result_stall;
  assign item_stall = stg_valid && !adv;
  assign fire       = stg_valid && adv;

  always_comb begin
    st_next = st;
    unique case (stg_command)
      CMD_REG_WRITE: begin
        unique case (stg_reg_select)
          REG_VOLUME: begin
            st_next.envelope_period = stg_data[3:0];
            st_next.constant_volume = stg_data[4];
            st_next.halt_pending    = 1'b1;
            st_next.halt_value      = stg_data[5];
            st_next.duty_mode       = stg_data[7:6];
          end
          REG_SWEEP: begin
            st_next.sweep_fields = stg_data;
            st_next.sweep_reload = 1'b1;
          end
          REG_PERIOD_LOW: begin
            st_next.period_value[7:0] = stg_data;
          end
          REG_PERIOD_HIGH: begin
            st_next.period_value[10:8] = stg_data[2:0];
            if (st.channel_enabled) begin
              st_next.length_count = LEN_TABLE[stg_data[7:3]];
            end
            st_next.sequence_position = 3'd0;
            st_next.envelope_start    = 1'b1;
          end
        endcase
      end
      CMD_ENABLE_WRITE: begin
        st_next.channel_enabled = stg_data[0];
        if (!stg_data[0]) begin
          st_next.length_count = 8'd0;
        end
      end
      CMD_TIMER_TICK: begin
        if (st.period_timer == 11'd0) begin
          st_next.period_timer      = st.period_value;
          st_next.sequence_position = st.sequence_position + 3'd1;
          st_next.wave_bit = DUTY_TABLE[{st.duty_mode, st_next.sequence_position}];
        end else begin
          st_next.period_timer = st.period_timer - 11'd1;
        end
        if (st.halt_pending) begin
          st_next.halt_loop    = st.halt_value;
          st_next.halt_pending = 1'b0;
          st_next.halt_value   = 1'b0;
        end
      end
      CMD_QUARTER_FRAME: begin
        st_next = clock_envelope(st);
      end
      CMD_HALF_FRAME: begin
        st_next = clock_sweep(clock_length(clock_envelope(st)), ones_complement_negate);
      end
      default: begin
        st_next = st;
      end
    endcase
  end

  always_comb begin
    if (st_next.length_count == 8'd0 ||
        sweep_mute(st_next.period_value, st_next.sweep_fields, ones_complement_negate)) begin
      vol = 4'd0;
    end else if (st_next.constant_volume) begin
      vol = st_next.envelope_period;
    end else begin
      vol = st_next.decay_level;
    end
    sample_next = st_next.wave_bit ? vol : 4'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ones_complement_negate <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      ones_complement_negate <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (!item_stall) begin
      stg_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      stg_command    <= command;
      stg_reg_select <= reg_select;
      stg_data       <= data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= '0;
      result_valid <= 1'b0;
    end else begin
      if (fire) begin
        st <= st_next;
      end
      if (adv) begin
        result_valid <= stg_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      sample        <= sample_next;
      length_active <= (st_next.length_count != 8'd0);
    end
  end

  `ASSERT_ALWAYS(a_sample_needs_length, clk, rst,
    !(result_valid && sample != 4'd0) || length_active)
  `ASSERT_ALWAYS(a_disabled_no_length, clk, rst,
    st.channel_enabled || st.length_count == 8'd0)
  `ASSERT_NEXT(a_stage_held, clk, rst, stg_valid && !adv,
    stg_valid && $stable(stg_command) && $stable(stg_data))

endmodule

### tb/tb_top.sv
// testbench for the square wave channel: tone predictor, request drivers and result checks
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sqw_pkg::*;

  localparam logic [2:0] CMD_RESERVED_LO = 3'd5;
  localparam logic [2:0] CMD_RESERVED_HI = 3'd7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD = 80;

  class tone_scoreboard;
    typedef struct packed {
      logic [3:0] sample;
      logic       active;
    } tone_out_t;

    bit [7:0] length_load [32] = '{
      8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
      8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
      8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
      8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
    };
    // one bit per sequencer position
    bit [7:0] duty_wave [4] = '{8'h02, 8'h06, 8'h1E, 8'hF9};

    bit        ones_neg;
    bit [1:0]  duty_mode;
    bit [2:0]  seq_pos;
    bit        wave;
    bit [10:0] tmr;
    bit [10:0] period;
    bit [3:0]  env_period;
    bit        steady_vol;
    bit        halt_loop;
    bit        halt_pend;
    bit        halt_val;
    bit        env_start;
    bit [3:0]  env_div;
    bit [3:0]  decay;
    bit [7:0]  len_cnt;
    bit        enabled;
    bit [7:0]  sweep;
    bit [2:0]  sweep_div;
    bit        sweep_reload;

    tone_out_t expected_q[$];
    int mismatches;

    function new();
      ones_neg = 1'b1;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int unsigned sweep_target();
      int unsigned p;
      int unsigned change;
      int unsigned sub;
      p = period;
      change = p >> sweep[2:0];
      if (sweep[3]) begin
        sub = change + ones_neg;
        return (sub > p) ? 0 : p - sub;
      end
      return p + change;
    endfunction

    function bit muted();
      return (sweep_target() > 'h7FF) || (period < 11'd8);
    endfunction

    function void envelope_clock();
      if (env_start) begin
        env_start = 1'b0;
        decay = 4'd15;
        env_div = env_period;
      end else if (env_div == 4'd0) begin
        env_div = env_period;
        if (decay == 4'd0) begin
          if (halt_loop) decay = 4'd15;
        end else begin
          decay--;
        end
      end else begin
        env_div--;
      end
    endfunction

    function void sweep_clock();
      int unsigned t;
      t = sweep_target();
      if (sweep_div == 3'd0 && sweep[7] && !muted() && sweep[2:0] != 3'd0)
        period = t[10:0];
      if (sweep_div == 3'd0 || sweep_reload) begin
        sweep_div = sweep[6:4];
        sweep_reload = 1'b0;
      end else begin
        sweep_div--;
      end
    endfunction

    function void timer_tick();
      if (tmr == 11'd0) begin
        tmr = period;
        seq_pos++;
        wave = duty_wave[duty_mode][seq_pos];
      end else begin
        tmr--;
      end
      if (halt_pend) begin
        halt_loop = halt_val;
        halt_pend = 1'b0;
      end
    endfunction

    function void write_register(logic [1:0] sel, logic [7:0] d);
      case (sel)
        REG_VOLUME: begin
          env_period = d[3:0];
          steady_vol = d[4];
          halt_pend = 1'b1;
          halt_val = d[5];
          duty_mode = d[7:6];
        end
        REG_SWEEP: begin
          sweep = d;
          sweep_reload = 1'b1;
        end
        REG_PERIOD_LOW: period[7:0] = d;
        default: begin
          period[10:8] = d[2:0];
          if (enabled) len_cnt = length_load[d[7:3]];
          seq_pos = 3'd0;
          env_start = 1'b1;
        end
      endcase
    endfunction

    function void note_input(logic [2:0] cmd, logic [1:0] sel, logic [7:0] d);
      tone_out_t r;
      bit [3:0] vol;
      case (cmd)
        CMD_REG_WRITE: write_register(sel, d);
        CMD_ENABLE_WRITE: begin
          enabled = d[0];
          if (!d[0]) len_cnt = 8'd0;
        end
        CMD_TIMER_TICK: timer_tick();
        CMD_QUARTER_FRAME: envelope_clock();
        CMD_HALF_FRAME: begin
          envelope_clock();
          if (!halt_loop && len_cnt != 8'd0) len_cnt--;
          sweep_clock();
        end
        default: ;
      endcase
      if (len_cnt == 8'd0 || muted()) vol = 4'd0;
      else if (steady_vol) vol = env_period;
      else vol = decay;
      r.sample = wave ? vol : 4'd0;
      r.active = (len_cnt != 8'd0);
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_result(logic [3:0] s, logic a);
      tone_out_t w;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result sample %0d length_active %0d", s, a));
      end else begin
        w = expected_q.pop_front();
        if (s !== w.sample)
          report($sformatf("sample got %0d expected %0d", s, w.sample));
        if (a !== w.active)
          report($sformatf("length_active got %0d expected %0d", a, w.active));
      end
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       item_valid;
  logic       item_stall;
  logic [2:0] command;
  logic [1:0] reg_select;
  logic [7:0] data;
  logic       result_valid;
  logic       result_stall;
  logic [3:0] sample;
  logic       length_active;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_data;

  tone_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_left;
  int cycle_count;
  bit hold_request;

  square_wave_channel_with_sweep u_top (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .command       (command),
    .reg_select    (reg_select),
    .data          (data),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .sample        (sample),
    .length_active (length_active),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side
  initial begin
    result_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall = 1'b1;
      end else begin
        result_stall = ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(sample, length_active);
  end

  // one request, held until taken
  task automatic send_item(logic [2:0] cmd, logic [1:0] sel, logic [7:0] d);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      item_valid = 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    item_valid = 1'b1;
    command = cmd;
    reg_select = sel;
    data = d;
    do @(posedge clk); while (item_stall);
    sb.note_input(cmd, sel, d);
  endtask

  task automatic drain();
    @(negedge clk);
    item_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_config(logic v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    sb.ones_neg = v;
    @(negedge clk);
    cfg_valid = 1'b0;
    @(posedge clk);
  endtask

  task automatic directed_items();
    send_item(CMD_TIMER_TICK, REG_VOLUME, 8'h00);
    for (int c = CMD_RESERVED_LO; c <= CMD_RESERVED_HI; c++)
      send_item(c[2:0], REG_PERIOD_HIGH, 8'hFF);
    send_item(CMD_REG_WRITE, REG_PERIOD_HIGH, 8'hFF);
    send_item(CMD_ENABLE_WRITE, REG_VOLUME, 8'h01);
    send_item(CMD_REG_WRITE, REG_VOLUME, 8'hBF);
    send_item(CMD_REG_WRITE, REG_PERIOD_LOW, 8'h00);
    send_item(CMD_REG_WRITE, REG_PERIOD_HIGH, 8'h09);
    send_item(CMD_HALF_FRAME, REG_VOLUME, 8'h00);
    send_item(CMD_TIMER_TICK, REG_VOLUME, 8'h00);
    send_item(CMD_HALF_FRAME, REG_VOLUME, 8'h00);
    send_item(CMD_REG_WRITE, REG_VOLUME, 8'h00);
    send_item(CMD_QUARTER_FRAME, REG_SWEEP, 8'hFF);
    // negate with zero shift floors the target at zero
    send_item(CMD_REG_WRITE, REG_SWEEP, 8'h88);
    send_item(CMD_HALF_FRAME, REG_VOLUME, 8'h00);
    send_item(CMD_REG_WRITE, REG_SWEEP, 8'hF1);
    send_item(CMD_REG_WRITE, REG_PERIOD_HIGH, 8'hFF);
    send_item(CMD_HALF_FRAME, REG_VOLUME, 8'h00);
    send_item(CMD_REG_WRITE, REG_PERIOD_HIGH, 8'h00);
    send_item(CMD_TIMER_TICK, REG_VOLUME, 8'h00);
    send_item(CMD_REG_WRITE, REG_PERIOD_LOW, 8'hFF);
    send_item(CMD_REG_WRITE, REG_SWEEP, 8'h7F);
    send_item(CMD_HALF_FRAME, REG_VOLUME, 8'h00);
    send_item(CMD_ENABLE_WRITE, REG_VOLUME, 8'hFE);
    send_item(CMD_TIMER_TICK, REG_VOLUME, 8'h00);
  endtask

  task automatic random_items(int count);
    int pick;
    logic [2:0] cmd;
    logic [1:0] sel;
    logic [7:0] d;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      sel = 2'($urandom_range(3));
      d = 8'($urandom_range(255));
      if (pick < 40) begin
        cmd = CMD_TIMER_TICK;
      end else if (pick < 52) begin
        cmd = CMD_QUARTER_FRAME;
      end else if (pick < 64) begin
        cmd = CMD_HALF_FRAME;
      end else if (pick < 86) begin
        cmd = CMD_REG_WRITE;
        // keep periods short so the sequencer moves
        if (sel == REG_PERIOD_LOW && $urandom_range(1) == 1) d = 8'($urandom_range(24, 8));
        if (sel == REG_PERIOD_HIGH && $urandom_range(3) != 0) d[2:0] = 3'($urandom_range(1));
      end else if (pick < 96) begin
        cmd = CMD_ENABLE_WRITE;
        d[0] = ($urandom_range(9) != 0);
      end else begin
        cmd = 3'($urandom_range(CMD_RESERVED_HI, CMD_RESERVED_LO));
      end
      send_item(cmd, sel, d);
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    item_valid = 1'b0;
    command = CMD_REG_WRITE;
    reg_select = REG_VOLUME;
    data = 8'h00;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_request = 1'b0;
    cycle_count = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(posedge clk);

    write_config(1'b1);
    directed_items();
    drain();

    write_config(1'b0);
    tx_idle_pct = 18;
    rx_idle_pct = 88;
    random_items(110);
    drain();
    random_items(110);
    drain();

    write_config(1'b1);
    tx_idle_pct = 88;
    rx_idle_pct = 18;
    random_items(210);
    drain();

    write_config(1'b0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_items(110);
    hold_request = 1'b1;
    random_items(110);
    drain();
    repeat (10) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### square_wave_channel_with_sweep.f
+incdir+sv
sv/sqw_pkg.sv
sv/square_wave_channel_with_sweep.sv
tb/tb_top.sv
